### src/kvat_pkg.sv
// ----------------------------------------------------------------------------
// kvat_pkg
// Shared constants, command/status codes and control types for the
// key/value association table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kvat_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int ECNT_W   = 5;

    // input beat: tdata = {value, key}, tuser = cmd
    localparam int IN_DATA_W = KEY_W + VAL_W;
    localparam int IN_USER_W = CMD_W;

    // output beat: tdata = {entry_count, status, read_value, found}
    localparam int OUT_FIELDS_W = 1 + VAL_W + STATUS_W + ECNT_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_ASSOC  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    // controller -> datapath commands
    typedef struct packed {
        logic load_in;   // capture the input beat
        logic match;     // register key compare / free slot search
        logic exec;      // apply command to table, read value memory
        logic load_out;  // load output register
    } t_dp_cmd;

endpackage

`default_nettype wire

### src/kvat_ctrl.sv
// ----------------------------------------------------------------------------
// kvat_ctrl
// Sequencer for the table: accept, match, execute, respond. Owns the input
// ready and output valid handshake state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kvat_ctrl
    import kvat_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  wire     i_out_ready,
    output t_dp_cmd o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MATCH = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;
    localparam logic [1:0] S_RESP  = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state          = r_state;
        n_out_valid      = r_out_valid;
        o_cmd            = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_MATCH;
                end
            end
            S_MATCH: begin
                o_cmd.match = 1'b1;
                n_state     = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_RESP;
            end
            S_RESP: begin
                // hold here while the previous result is still stalled
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

### src/kvat_dpath.sv
// ----------------------------------------------------------------------------
// kvat_dpath
// Table datapath: key slots with parallel compare, valid bits, value memory,
// entry counter and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kvat_dpath
    import kvat_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  t_dp_cmd               i_cmd,
    input  wire [IN_DATA_W-1:0]   i_in_data,   // [31:0] key, [63:32] value
    input  wire [IN_USER_W-1:0]   i_in_user,   // [1:0] cmd
    output logic [OUT_DATA_W-1:0] o_out_data   // found, read_value, status, entry_count
);

    // captured beat
    logic [CMD_W-1:0] r_cmd;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_val;

    // table state
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [KEY_W-1:0]       r_keys [TABLE_DEPTH];
    logic [VAL_W-1:0]       r_vmem [TABLE_DEPTH];
    logic [CNT_W-1:0]       r_count;

    // match stage
    logic [TABLE_DEPTH-1:0] w_match;
    logic [IDX_W-1:0]       w_hit_idx;
    logic [IDX_W-1:0]       w_free_idx;
    logic                   r_present;
    logic                   r_full;
    logic [IDX_W-1:0]       r_hit_idx;
    logic [IDX_W-1:0]       r_free_idx;

    // exec stage results
    logic                   r_found;
    logic [STATUS_W-1:0]    r_status;
    logic                   r_rd_sel;
    logic [VAL_W-1:0]       r_rd_data;
    logic                   w_insert;
    logic                   w_vwr;
    logic [IDX_W-1:0]       w_vwr_idx;

    logic [OUT_DATA_W-1:0]  r_out_data;
    logic [VAL_W-1:0]       w_rd_value;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cmd <= i_in_user;
            r_key <= i_in_data[KEY_W-1:0];
            r_val <= i_in_data[KEY_W +: VAL_W];
        end
    end

    // parallel compare, lowest index wins
    always_comb begin
        w_hit_idx  = '0;
        w_free_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            w_match[i] = r_valid[i] && (r_keys[i] == r_key);
            if (w_match[i]) begin
                w_hit_idx = IDX_W'(i);
            end
            if (!r_valid[i]) begin
                w_free_idx = IDX_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.match) begin
            r_present  <= |w_match;
            r_full     <= &r_valid;
            r_hit_idx  <= w_hit_idx;
            r_free_idx <= w_free_idx;
        end
    end

    assign w_insert  = (r_cmd == CMD_ASSOC) && !r_present && !r_full;
    assign w_vwr     = i_cmd.exec && (r_cmd == CMD_ASSOC) && (r_present || !r_full);
    assign w_vwr_idx = r_present ? r_hit_idx : r_free_idx;

    // valid bits and counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            if (w_insert) begin
                r_valid[r_free_idx] <= 1'b1;
                r_count             <= r_count + CNT_W'(1);
            end else if ((r_cmd == CMD_REMOVE) && r_present) begin
                r_valid[r_hit_idx] <= 1'b0;
                r_count            <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_insert) begin
            r_keys[r_free_idx] <= r_key;
        end
    end

    // value memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_vwr) begin
            r_vmem[w_vwr_idx] <= r_val;
        end
        if (i_cmd.exec) begin
            r_rd_data <= r_vmem[r_hit_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_found  <= 1'b0;
            r_status <= ST_OK;
            r_rd_sel <= 1'b0;
            case (r_cmd)
                CMD_ASSOC: begin
                    r_found <= r_present;
                    if (!r_present && r_full) begin
                        r_status <= ST_FULL;
                    end
                end
                CMD_LOOKUP: begin
                    r_found  <= r_present;
                    r_rd_sel <= r_present;
                    if (!r_present) begin
                        r_status <= ST_MISSING;
                    end
                end
                CMD_REMOVE: begin
                    r_found <= r_present;
                    if (!r_present) begin
                        r_status <= ST_MISSING;
                    end
                end
                default: begin
                    // unused code: no change, plain ok result
                end
            endcase
        end
    end

    assign w_rd_value = r_rd_sel ? r_rd_data : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= OUT_DATA_W'({ECNT_W'(r_count), r_status, w_rd_value, r_found});
        end
    end

    assign o_out_data = r_out_data;

endmodule

`default_nettype wire

### src/key_value_assoc_table.sv
// ----------------------------------------------------------------------------
// key_value_assoc_table
// Bounded associative key/value table (TABLE_DEPTH slots) driven by
// associate, lookup and remove commands.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one command per beat: tuser = cmd, tdata = key and
//   value. Master stream returns one result beat per command: found,
//   read_value, status and the entry count after the command.
//   Each command runs through capture, parallel key compare and free-slot
//   search, table update with value-memory read, and output load, in order.
//   Input ready is high only in the idle step, so a new command is taken
//   only once the previous one has loaded its result; the compare/update
//   sequence and the registered value-memory read set these steps.
//   The output register holds one finished result, so the next command is
//   accepted and processed while that result waits. If the receiver stalls,
//   the sequencer holds in its response step until the output beat is taken.
//   Reset (synchronous, active low) empties the table at once: valid bits
//   and the entry count clear; key and value storage is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module key_value_assoc_table
    import kvat_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire [IN_DATA_W-1:0]   s_axis_tdata,   // [31:0] key, [63:32] value
    input  wire [IN_USER_W-1:0]   s_axis_tuser,   // [1:0] cmd
    output logic                  m_axis_tvalid,
    input  wire                   m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // [0] found, [32:1] read_value,
                                                  // [34:33] status, [39:35] entry_count
);

    t_dp_cmd w_cmd;

    kvat_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd)
    );

    kvat_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_in_data  (s_axis_tdata),
        .i_in_user  (s_axis_tuser),
        .o_out_data (m_axis_tdata)
    );

endmodule

`default_nettype wire

### src/kvat_checker.sv
// ----------------------------------------------------------------------------
// kvat_checker
// Port-level checks for the key/value table, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kvat_checker
    import kvat_pkg::*;
(
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  i_s_tvalid,
    input wire                  i_s_tready,
    input wire                  i_m_tvalid,
    input wire                  i_m_tready,
    input wire [OUT_DATA_W-1:0] i_m_tdata
);

    logic                w_found;
    logic [VAL_W-1:0]    w_rd;
    logic [STATUS_W-1:0] w_status;
    logic [ECNT_W-1:0]   w_ecnt;

    assign w_found  = i_m_tdata[0];
    assign w_rd     = i_m_tdata[VAL_W:1];
    assign w_status = i_m_tdata[VAL_W+1 +: STATUS_W];
    assign w_ecnt   = i_m_tdata[VAL_W+1+STATUS_W +: ECNT_W];

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("result beat changed while stalled");

    // one command in flight: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready |=> !i_s_tready)
        else $error("input ready right after accept");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && w_found |-> w_status == ST_OK)
        else $error("found with non-ok status");

    a_rd_needs_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && (w_rd != '0) |-> w_found)
        else $error("read value without a hit");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (TABLE_DEPTH > 31) || (int'(w_ecnt) <= TABLE_DEPTH))
        else $error("entry count exceeds table depth");

endmodule

bind key_value_assoc_table kvat_checker u_kvat_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);

`default_nettype wire

### tb/key_value_assoc_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_value_assoc_table_tb
// Self-checking bench for the key/value association table. Commands go in on
// the slave stream and results are checked on the master stream, in order,
// against a shadow copy of the table. Random idle and stall cycles on both
// sides, one long receiver hold-off and two full drains of the pipeline.
// ----------------------------------------------------------------------------

module key_value_assoc_table_tb;

    import kvat_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;   // not decoded by the block
    localparam int CLK_HALF     = 4;
    localparam int RST_CYCLES   = 6;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int KEY_POOL_N   = 24;

    typedef struct {
        logic                found;
        logic [VAL_W-1:0]    read_value;
        logic [STATUS_W-1:0] status;
        logic [ECNT_W-1:0]   entry_count;
    } t_kv_result;

    // Shadow table plus the queue of results still owed by the block.
    class kv_table_checker;
        bit               model_used [TABLE_DEPTH];
        logic [KEY_W-1:0] model_key  [TABLE_DEPTH];
        logic [VAL_W-1:0] model_val  [TABLE_DEPTH];
        int unsigned      entries;
        t_kv_result       expected_results[$];
        int               errors;
        int               beats_in, beats_out;
        int               n_cmd[4];
        int               n_full, n_missing, n_hit, peak_entries;

        function new();
            for (int i = 0; i < TABLE_DEPTH; i++) model_used[i] = 1'b0;
            entries = 0;
            errors = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        task log_mismatch(string msg);
            errors++;
            $display("[%0t] MISMATCH: %s", $time, msg);
        endtask

        function void note_command(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                   logic [VAL_W-1:0] value);
            int         hit;
            int         free_idx;
            t_kv_result res;
            hit = -1;
            free_idx = -1;
            for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
                if (model_used[i] && model_key[i] == key) hit = i;
                if (!model_used[i]) free_idx = i;
            end
            res.found = 1'b0;
            res.read_value = '0;
            res.status = ST_OK;
            case (cmd)
                CMD_ASSOC: begin
                    if (hit >= 0) begin
                        res.found = 1'b1;
                        model_val[hit] = value;
                    end else if (free_idx >= 0) begin
                        model_used[free_idx] = 1'b1;
                        model_key[free_idx] = key;
                        model_val[free_idx] = value;
                        entries++;
                    end else begin
                        res.status = ST_FULL;
                    end
                end
                CMD_LOOKUP: begin
                    if (hit >= 0) begin
                        res.found = 1'b1;
                        res.read_value = model_val[hit];
                    end else begin
                        res.status = ST_MISSING;
                    end
                end
                CMD_REMOVE: begin
                    if (hit >= 0) begin
                        res.found = 1'b1;
                        model_used[hit] = 1'b0;
                        if (entries > 0) entries--;
                    end else begin
                        res.status = ST_MISSING;
                    end
                end
                default: ;
            endcase
            res.entry_count = entries[ECNT_W-1:0];
            expected_results.push_back(res);
            beats_in++;
            n_cmd[cmd]++;
            if (res.status == ST_FULL) n_full++;
            if (res.status == ST_MISSING) n_missing++;
            if (res.found) n_hit++;
            if (entries > peak_entries) peak_entries = entries;
        endfunction

        task check_result(logic [OUT_DATA_W-1:0] beat);
            t_kv_result want;
            int         idx;
            idx = beats_out;
            beats_out++;
            if (expected_results.size() == 0) begin
                log_mismatch($sformatf("result beat %0d with nothing expected (tdata=%h)",
                                       idx, beat));
            end else begin
                want = expected_results.pop_front();
                if (beat[0] !== want.found)
                    log_mismatch($sformatf("beat %0d found %b, want %b",
                                           idx, beat[0], want.found));
                if (beat[VAL_W:1] !== want.read_value)
                    log_mismatch($sformatf("beat %0d read_value %h, want %h",
                                           idx, beat[VAL_W:1], want.read_value));
                if (beat[VAL_W+STATUS_W:VAL_W+1] !== want.status)
                    log_mismatch($sformatf("beat %0d status %0d, want %0d",
                                           idx, beat[VAL_W+STATUS_W:VAL_W+1], want.status));
                if (beat[VAL_W+STATUS_W+ECNT_W:VAL_W+STATUS_W+1] !== want.entry_count)
                    log_mismatch($sformatf("beat %0d entry_count %0d, want %0d", idx,
                                           beat[VAL_W+STATUS_W+ECNT_W:VAL_W+STATUS_W+1],
                                           want.entry_count));
            end
        endtask

        task check_drained();
            if (expected_results.size() != 0)
                log_mismatch($sformatf("%0d results never arrived",
                                       expected_results.size()));
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // [31:0] key, [63:32] value
    logic [IN_USER_W-1:0]  s_axis_tuser;   // [1:0] cmd
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // [0] found, [32:1] read_value,
                                           // [34:33] status, [39:35] entry_count

    kv_table_checker  table_chk = new();
    logic [KEY_W-1:0] key_pool[KEY_POOL_N];
    bit               rx_steady;
    bit               rx_hold_req;

    key_value_assoc_table i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // result side: stall pattern driven on the falling edge
    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                rx_hold_req = 1'b0;
            end else if (rx_steady) begin
                m_axis_tready = 1'b1;
            end else begin
                m_axis_tready = ($urandom_range(99) >= 24);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            table_chk.check_result(m_axis_tdata);
    end

    // watchdog: cycles with no beat on either side
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
                (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("Timeout: no beat for %0d cycles, %0d results outstanding",
                         quiet, table_chk.pending());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                            logic [VAL_W-1:0] value, bit allow_gap);
        if (allow_gap) begin
            while ($urandom_range(99) < 24) begin
                s_axis_tvalid = 1'b0;
                @(negedge i_clk);
            end
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = cmd;
        s_axis_tdata  = {value, key};
        do @(posedge i_clk); while (!s_axis_tready);
        table_chk.note_command(cmd, key, value);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid = 1'b0;
        while (table_chk.pending() != 0) @(negedge i_clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(99) < 85)
            return key_pool[$urandom_range(KEY_POOL_N - 1)];
        return $urandom;
    endfunction

    task automatic directed_cmds();
        send_cmd(CMD_LOOKUP, 32'h0, 32'h0, 1'b1);            // empty table
        send_cmd(CMD_REMOVE, 32'hFFFF_FFFF, 32'h0, 1'b1);
        send_cmd(CMD_UNUSED, 32'h1234_5678, 32'hFFFF_FFFF, 1'b1);
        send_cmd(CMD_ASSOC, 32'h0, 32'h0, 1'b1);
        send_cmd(CMD_ASSOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_cmd(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0, 1'b1);
        send_cmd(CMD_ASSOC, 32'h0, 32'hA5A5_5A5A, 1'b1);     // overwrite, count holds
        send_cmd(CMD_LOOKUP, 32'h0, 32'h0, 1'b1);
        for (int i = 2; i < TABLE_DEPTH; i++)
            send_cmd(CMD_ASSOC, key_pool[i], $urandom, 1'b0);
        send_cmd(CMD_ASSOC, key_pool[TABLE_DEPTH], 32'h5555_AAAA, 1'b1);  // refused
        send_cmd(CMD_ASSOC, 32'hFFFF_FFFF, 32'h0, 1'b1);     // update while full
        send_cmd(CMD_REMOVE, key_pool[7], 32'h0, 1'b1);
        send_cmd(CMD_ASSOC, key_pool[TABLE_DEPTH], 32'h0F0F_F0F0, 1'b1);  // takes hole
        send_cmd(CMD_UNUSED, 32'h0, 32'h0, 1'b1);
        send_cmd(CMD_LOOKUP, key_pool[7], 32'h0, 1'b1);
    endtask

    task automatic random_cmds(int n, int assoc_pct, int lookup_pct, int remove_pct,
                               bit allow_gap);
        int               roll;
        logic [CMD_W-1:0] cmd;
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(99);
            if (roll < assoc_pct)
                cmd = CMD_ASSOC;
            else if (roll < assoc_pct + lookup_pct)
                cmd = CMD_LOOKUP;
            else if (roll < assoc_pct + lookup_pct + remove_pct)
                cmd = CMD_REMOVE;
            else
                cmd = CMD_UNUSED;
            send_cmd(cmd, pick_key(), $urandom, allow_gap);
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_ASSOC;
        rx_steady     = 1'b0;
        rx_hold_req   = 1'b0;
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < KEY_POOL_N; i++) key_pool[i] = $urandom;
        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        directed_cmds();
        random_cmds(250, 50, 25, 20, 1'b1);

        // back-to-back stretch, no idling on either side
        rx_steady = 1'b1;
        random_cmds(150, 35, 35, 25, 1'b0);
        rx_steady = 1'b0;

        // let the pipe run dry, then stall the result side while commands pile up
        drain_results();
        rx_hold_req = 1'b1;
        random_cmds(150, 25, 30, 40, 1'b1);
        random_cmds(150, 45, 30, 20, 1'b1);

        drain_results();
        repeat (16) @(negedge i_clk);
        table_chk.check_drained();

        $display("Ran %0d commands: %0d associate, %0d lookup, %0d remove, %0d unused code",
                 table_chk.beats_in, table_chk.n_cmd[CMD_ASSOC], table_chk.n_cmd[CMD_LOOKUP],
                 table_chk.n_cmd[CMD_REMOVE], table_chk.n_cmd[CMD_UNUSED]);
        $display("Key hits %0d, misses %0d, full refusals %0d, peak occupancy %0d of %0d",
                 table_chk.n_hit, table_chk.n_missing, table_chk.n_full,
                 table_chk.peak_entries, TABLE_DEPTH);
        if (table_chk.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### filelist.f
src/kvat_pkg.sv
src/kvat_ctrl.sv
src/kvat_dpath.sv
src/key_value_assoc_table.sv
src/kvat_checker.sv
tb/key_value_assoc_table_tb.sv
